[hw/rtl/hap_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP action response parser package
// Shared byte codes, prefix lookup and the request/result types.
// ----------------------------------------------------------------------------
package hap_pkg;

    localparam int unsigned PrefixLen = 12;
    localparam logic [3:0]  Halted    = 4'd15;

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharPlus  = 8'h2b;
    localparam logic [7:0] CharComma = 8'h2c;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    localparam int unsigned OutDataWidth = 56;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    // Packed so that prefix_found sits in bit 0 of the output tdata.
    typedef struct packed {
        logic        pad;
        logic [31:0] body_length;
        logic        length_seen;
        logic [3:0]  status_ones;
        logic [3:0]  status_tens;
        logic [3:0]  status_hundreds;
        logic        status_seen;
        logic [7:0]  method_code;
        logic        prefix_found;
    } result_t;

    function automatic logic [7:0] prefix_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h2b;  // +
            4'd1:    b = 8'h48;  // H
            4'd2:    b = 8'h54;  // T
            4'd3:    b = 8'h54;  // T
            4'd4:    b = 8'h50;  // P
            4'd5:    b = 8'h41;  // A
            4'd6:    b = 8'h43;  // C
            4'd7:    b = 8'h54;  // T
            4'd8:    b = 8'h49;  // I
            4'd9:    b = 8'h4f;  // O
            4'd10:   b = 8'h4e;  // N
            4'd11:   b = 8'h3a;  // :
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/hap_core.sv]
// ----------------------------------------------------------------------------
// HTTP action response parser core
// Holds the parse state and applies one byte per advance; builds the result
// on the last byte and clears the state.
// ----------------------------------------------------------------------------
module hap_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  hap_pkg::item_t   item,
    output hap_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_METHOD,
        PH_SEEK1,
        PH_STATUS,
        PH_SEEK2,
        PH_LENGTH
    } phase_t;

    logic [3:0]  match_reg,  match_next,  match_upd;
    phase_t      phase_reg,  phase_next,  phase_upd;
    logic [7:0]  method_reg, method_next, method_upd;
    logic [3:0]  hund_reg,   hund_next,   hund_upd;
    logic [3:0]  tens_reg,   tens_next,   tens_upd;
    logic [3:0]  ones_reg,   ones_next,   ones_upd;
    logic [31:0] length_reg, length_next, length_upd;

    logic        is_digit;
    logic [3:0]  digit;
    logic        active;
    logic        pf;
    logic        ss;
    logic        ls;

    assign is_digit = (item.ch >= hap_pkg::CharZero) && (item.ch <= hap_pkg::CharNine);
    assign digit    = 4'(item.ch - hap_pkg::CharZero);
    assign active   = advance && (match_reg != hap_pkg::Halted) && (phase_reg <= PH_LENGTH);

    always_comb
    begin
        match_upd  = match_reg;
        phase_upd  = phase_reg;
        method_upd = method_reg;
        hund_upd   = hund_reg;
        tens_upd   = tens_reg;
        ones_upd   = ones_reg;
        length_upd = length_reg;
        if (active)
        begin
            if (item.ch == hap_pkg::CharNul)
            begin
                match_upd = hap_pkg::Halted;
            end
            else
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if ((32'(match_reg) < hap_pkg::PrefixLen) &&
                            (item.ch == hap_pkg::prefix_byte(match_reg)))
                        begin
                            if (32'(match_reg) == hap_pkg::PrefixLen - 1)
                            begin
                                match_upd = 4'd0;
                                phase_upd = PH_SKIP;
                            end
                            else
                            begin
                                match_upd = match_reg + 4'd1;
                            end
                        end
                        else if (item.ch == hap_pkg::CharPlus)
                        begin
                            match_upd = 4'd1;
                        end
                        else
                        begin
                            match_upd = 4'd0;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (item.ch == hap_pkg::CharSpace)
                        begin
                            phase_upd = PH_SKIP;
                        end
                        else if (is_digit)
                        begin
                            method_upd = {4'd0, digit};
                            phase_upd  = PH_METHOD;
                        end
                        else if (item.ch == hap_pkg::CharComma)
                        begin
                            phase_upd = PH_STATUS;
                        end
                        else
                        begin
                            phase_upd = PH_SEEK1;
                        end
                    end
                    PH_METHOD:
                    begin
                        if (is_digit)
                        begin
                            method_upd = (method_reg << 3) + (method_reg << 1) + {4'd0, digit};
                        end
                        else if (item.ch == hap_pkg::CharComma)
                        begin
                            phase_upd = PH_STATUS;
                        end
                        else
                        begin
                            phase_upd = PH_SEEK1;
                        end
                    end
                    PH_SEEK1:
                    begin
                        if (item.ch == hap_pkg::CharComma)
                        begin
                            phase_upd = PH_STATUS;
                        end
                    end
                    PH_STATUS:
                    begin
                        // shift digits; keep the low three decimal digits
                        if (is_digit)
                        begin
                            hund_upd = tens_reg;
                            tens_upd = ones_reg;
                            ones_upd = digit;
                        end
                        else if (item.ch == hap_pkg::CharComma)
                        begin
                            phase_upd = PH_LENGTH;
                        end
                        else
                        begin
                            phase_upd = PH_SEEK2;
                        end
                    end
                    PH_SEEK2:
                    begin
                        if (item.ch == hap_pkg::CharComma)
                        begin
                            phase_upd = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (is_digit)
                        begin
                            length_upd = (length_reg << 3) + (length_reg << 1) + {28'd0, digit};
                        end
                        else
                        begin
                            match_upd = hap_pkg::Halted;
                        end
                    end
                    default:
                    begin
                        match_upd = hap_pkg::Halted;
                    end
                endcase
            end
        end
    end

    assign pf = (phase_upd >= PH_SKIP) && (phase_upd <= PH_LENGTH);
    assign ss = (phase_upd >= PH_STATUS) && (phase_upd <= PH_LENGTH);
    assign ls = (phase_upd == PH_LENGTH);

    always_comb
    begin
        result.pad             = 1'b0;
        result.prefix_found    = pf;
        result.method_code     = pf ? method_upd : 8'd0;
        result.status_seen     = ss;
        result.status_hundreds = ss ? hund_upd : 4'd0;
        result.status_tens     = ss ? tens_upd : 4'd0;
        result.status_ones     = ss ? ones_upd : 4'd0;
        result.length_seen     = ls;
        result.body_length     = ls ? length_upd : 32'd0;
    end

    always_comb
    begin
        if (advance && item.last)
        begin
            match_next  = 4'd0;
            phase_next  = PH_SEARCH;
            method_next = 8'd0;
            hund_next   = 4'd0;
            tens_next   = 4'd0;
            ones_next   = 4'd0;
            length_next = 32'd0;
        end
        else
        begin
            match_next  = match_upd;
            phase_next  = phase_upd;
            method_next = method_upd;
            hund_next   = hund_upd;
            tens_next   = tens_upd;
            ones_next   = ones_upd;
            length_next = length_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg  <= 4'd0;
            phase_reg  <= PH_SEARCH;
            method_reg <= 8'd0;
            hund_reg   <= 4'd0;
            tens_reg   <= 4'd0;
            ones_reg   <= 4'd0;
            length_reg <= 32'd0;
        end
        else
        begin
            match_reg  <= match_next;
            phase_reg  <= phase_next;
            method_reg <= method_next;
            hund_reg   <= hund_next;
            tens_reg   <= tens_next;
            ones_reg   <= ones_next;
            length_reg <= length_next;
        end
    end

endmodule

[hw/rtl/http_action_response_parser.sv]
// ----------------------------------------------------------------------------
// HTTP action response parser
// Parses a "+HTTPACTION:" modem response one byte per request and returns
// method, status digits and body length after the last byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while intake does not pause. Each
// byte passes an input register and one short update stage on the parse
// state; a request with tlast, once it leaves the input register, loads the
// result register, which raises m_tvalid. Intake pauses only while a result
// waits in the output register and the byte in the input register is itself
// a last byte. Bytes after a zero byte, or after a non-digit that ends the
// length field, are consumed without effect until the last byte.
module http_action_response_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [0] prefix_found, [8:1] method_code,
                                   // [9] status_seen, [13:10] status_hundreds,
                                   // [17:14] status_tens, [21:18] status_ones,
                                   // [22] length_seen, [54:23] body_length,
                                   // [55] zero
);

    logic             in_valid_reg, in_valid_next;
    hap_pkg::item_t   in_item_reg,  in_item_next;
    logic             out_valid_reg, out_valid_next;
    hap_pkg::result_t out_data_reg,  out_data_next;

    hap_pkg::result_t step_result;
    logic             out_free;
    logic             in_go;
    logic             advance;
    logic             s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign in_go    = !in_item_reg.last || out_free;
    assign advance  = in_valid_reg && in_go;
    assign s_tready = !in_valid_reg || in_go;
    assign s_accept = s_tvalid && s_tready;

    hap_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept)
        begin
            in_valid_next     = 1'b1;
            in_item_next.ch   = s_tdata;
            in_item_next.last = s_tlast;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance && in_item_reg.last)
        begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hap_pkg::OutDataWidth'(out_data_reg);

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_item_reg.last))
        else $error("result appeared without a last byte");

    a_flag_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_data_reg.length_seen || out_data_reg.status_seen) &&
                           (!out_data_reg.status_seen || out_data_reg.prefix_found)))
        else $error("result flags out of order");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.status_hundreds <= 4'd9) &&
                           (out_data_reg.status_tens <= 4'd9) &&
                           (out_data_reg.status_ones <= 4'd9)))
        else $error("status digit out of decimal range");

    a_cleared_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.prefix_found) |->
            ((out_data_reg.method_code == 8'd0) && (out_data_reg.body_length == 32'd0)))
        else $error("fields set without prefix");

endmodule
